>>> hdl/radix2_fft_engine_defines.svh
// assertion macros for the radix-2 fft engine checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef RADIX2_FFT_ENGINE_DEFINES_SVH
`define RADIX2_FFT_ENGINE_DEFINES_SVH

// same-cycle implication
`define R2F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define R2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/r2fft_pkg.sv
// shared constants, types and functions of the radix-2 fft engine
// no dependencies
package r2fft_pkg;

  localparam int STORE_DEPTH     = 64;
  localparam int ADDR_W          = 6;
  localparam int LVL_W           = 3;
  localparam int DATA_W          = 24;
  localparam int TW_W            = 16;
  localparam int TW_FRAC         = 15;
  localparam int PROD_W          = DATA_W + TW_W;
  localparam int POINTS_DEF      = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // butterfly datapath strobes
  typedef struct packed {
    logic cap_a;
    logic mul;
    logic add;
    logic inv;
  } bfly_ctrl_t;

  // quarter wave cosine, 1.0 held as 32767
  function automatic logic signed [TW_W-1:0] quarter_cos(input logic [4:0] t);
    logic signed [TW_W-1:0] v;
    case (t)
      5'd0:    v = 16'sd32767;
      5'd1:    v = 16'sd32610;
      5'd2:    v = 16'sd32138;
      5'd3:    v = 16'sd31357;
      5'd4:    v = 16'sd30274;
      5'd5:    v = 16'sd28899;
      5'd6:    v = 16'sd27246;
      5'd7:    v = 16'sd25330;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd20788;
      5'd10:   v = 16'sd18205;
      5'd11:   v = 16'sd15447;
      5'd12:   v = 16'sd12540;
      5'd13:   v = 16'sd9512;
      5'd14:   v = 16'sd6393;
      5'd15:   v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] rom_cos(input logic [ADDR_W-1:0] t);
    logic signed [TW_W-1:0] v;
    if (t <= 6'd16) begin
      v = quarter_cos(5'(t));
    end else if (t <= 6'd32) begin
      v = -quarter_cos(5'(6'd32 - t));
    end else if (t <= 6'd48) begin
      v = -quarter_cos(5'(t - 6'd32));
    end else begin
      v = quarter_cos(5'(7'd64 - 7'(t)));
    end
    return v;
  endfunction

  function automatic logic signed [TW_W-1:0] rom_sin(input logic [ADDR_W-1:0] t);
    return rom_cos(t + 6'd48);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [28:0] x);
    logic signed [DATA_W-1:0] v;
    if (x > 29'sd8388607) begin
      v = 24'sh7fffff;
    end else if (x < -29'sd8388608) begin
      v = 24'sh800000;
    end else begin
      v = 24'(x);
    end
    return v;
  endfunction

endpackage

>>> hdl/r2fft_if.sv
// valid/ready channel interfaces for samples and bins
// depends on nothing
interface r2fft_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  logic               frame_end;
  modport source (output valid, sample_re, sample_im, frame_end, input ready);
  modport sink (input valid, sample_re, sample_im, frame_end, output ready);
endinterface

interface r2fft_bin_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] bin_re;
  logic signed [23:0] bin_im;
  logic [5:0]         bin_index;
  logic               bin_last;
  modport source (output valid, bin_re, bin_im, bin_index, bin_last, input ready);
  modport sink (input valid, bin_re, bin_im, bin_index, bin_last, output ready);
endinterface

>>> hdl/r2fft_bfly.sv
// butterfly datapath: twiddle rom, complex multiply, sum and difference
// depends on r2fft_pkg
module r2fft_bfly (
  input  logic                                 clk_i,
  input  r2fft_pkg::bfly_ctrl_t                ctrl_i,
  input  logic [2*r2fft_pkg::DATA_W-1:0]       rd_i,
  input  logic [r2fft_pkg::ADDR_W-1:0]         ang_i,
  output logic [2*r2fft_pkg::DATA_W-1:0]       sum_o,
  output logic [2*r2fft_pkg::DATA_W-1:0]       diff_o
);

  logic signed [r2fft_pkg::DATA_W-1:0] a_re_q, a_im_q, b_re, b_im;
  logic signed [r2fft_pkg::TW_W-1:0]   wr, ws, wi;
  logic signed [r2fft_pkg::PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [40:0]                  t_re, t_im;
  logic signed [26:0]                  pr_q, pi_q;
  logic signed [28:0]                  s_re, s_im, d_re, d_im, rnd;

  assign b_re = rd_i[2*r2fft_pkg::DATA_W-1:r2fft_pkg::DATA_W];
  assign b_im = rd_i[r2fft_pkg::DATA_W-1:0];

  // twiddle, conjugated for the forward direction
  assign wr = r2fft_pkg::rom_cos(ang_i);
  assign ws = r2fft_pkg::rom_sin(ang_i);
  assign wi = ctrl_i.inv ? ws : -ws;

  // capture a, then the four partial products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_a) begin
      a_re_q <= b_re;
      a_im_q <= b_im;
    end
    if (ctrl_i.mul) begin
      p_rr_q <= 40'(b_re) * 40'(wr);
      p_ii_q <= 40'(b_im) * 40'(wi);
      p_ri_q <= 40'(b_re) * 40'(wi);
      p_ir_q <= 40'(b_im) * 40'(wr);
    end
    if (ctrl_i.add) begin
      pr_q <= 27'(t_re >>> r2fft_pkg::TW_FRAC);
      pi_q <= 27'(t_im >>> r2fft_pkg::TW_FRAC);
    end
  end

  // round to nearest, ties up
  assign t_re = 41'(p_rr_q) - 41'(p_ii_q) + 41'sd16384;
  assign t_im = 41'(p_ri_q) + 41'(p_ir_q) + 41'sd16384;

  // sum and difference, halved with rounding in inverse mode
  assign rnd  = ctrl_i.inv ? 29'sd1 : 29'sd0;
  assign s_re = 29'(a_re_q) + 29'(pr_q) + rnd;
  assign s_im = 29'(a_im_q) + 29'(pi_q) + rnd;
  assign d_re = 29'(a_re_q) - 29'(pr_q) + rnd;
  assign d_im = 29'(a_im_q) - 29'(pi_q) + rnd;

  assign sum_o  = ctrl_i.inv
    ? {r2fft_pkg::sat24(s_re >>> 1), r2fft_pkg::sat24(s_im >>> 1)}
    : {r2fft_pkg::sat24(s_re), r2fft_pkg::sat24(s_im)};
  assign diff_o = ctrl_i.inv
    ? {r2fft_pkg::sat24(d_re >>> 1), r2fft_pkg::sat24(d_im >>> 1)}
    : {r2fft_pkg::sat24(d_re), r2fft_pkg::sat24(d_im)};

endmodule

>>> hdl/radix2_fft_engine.sv
// radix-2 dit fft engine: work memory, load/transform/unload sequencer
// transform: each butterfly steps through ra, rb, mul, add, wa and wb; unload: ord, ocap and out per bin
// throughput: one sample per cycle while loading; the next frame is taken only after the last bin is accepted
// all memory traffic goes through one single-port-read, single-write work memory
// reset clears the sequencer, sample count and inv_q; memory contents are not cleared
module radix2_fft_engine #(
  parameter int POINTS      = r2fft_pkg::POINTS_DEF,
  parameter int SAMPLE_BITS = r2fft_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  r2fft_smp_if.sink    sample_in,
  r2fft_bin_if.source  bin_out
);

  localparam int AW = r2fft_pkg::ADDR_W;
  localparam int DW = r2fft_pkg::DATA_W;
  localparam int TB = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_RA   = 4'd1;
  localparam logic [3:0] ST_RB   = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ADD  = 4'd4;
  localparam logic [3:0] ST_WA   = 4'd5;
  localparam logic [3:0] ST_WB   = 4'd6;
  localparam logic [3:0] ST_ORD  = 4'd7;
  localparam logic [3:0] ST_OCAP = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic          inv_q;
  logic [AW:0]   count_q, count_d, n_q, n_d, n_new;
  logic [2:0]    lvl_q, lvl_d, stg_q, stg_d;
  logic [AW-2:0] j_q, j_d;
  logic [AW-1:0] k_q, k_d;

  logic [2*DW-1:0] mem [r2fft_pkg::STORE_DEPTH];
  logic [2*DW-1:0] rdata_q, rd_mux, wdata, sum, diff;
  logic [AW-1:0]   raddr, waddr;
  logic            we;

  logic [AW-1:0] j6, hmask, la, lb, pa, pb, ang, jlast, mlast;
  logic          in_acc, out_acc, zero_rd;
  logic signed [DW-1:0] s_re, s_im;
  r2fft_pkg::bfly_ctrl_t ctrl;

  logic signed [DW-1:0] bin_re_q, bin_im_q;
  logic [AW-1:0]        bin_index_q;
  logic                 bin_last_q;

  // bit reversal over the active number of levels
  function automatic logic [AW-1:0] rev(input logic [AW-1:0] x, input logic [2:0] lv);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = x[AW-1-b];
    end
    return r >> (3'(AW) - lv);
  endfunction

  // smallest level count whose power of two covers n
  function automatic logic [2:0] clog2n(input logic [AW:0] n);
    logic [2:0] l;
    l = 3'd0;
    for (int i = 0; i < AW; i++) begin
      if ((7'd1 << l) < n) begin
        l = l + 3'd1;
      end
    end
    return l;
  endfunction

  // sample field taken at the configured width, capped at 16 bits
  function automatic logic signed [DW-1:0] take(input logic [15:0] raw);
    logic signed [DW-1:0] v;
    if (SAMPLE_BITS <= 16) begin
      v = DW'(signed'(raw[TB-1:0]));
    end else begin
      v = DW'(raw);
    end
    return v;
  endfunction

  assign in_acc  = sample_in.valid && sample_in.ready;
  assign out_acc = bin_out.valid && bin_out.ready;
  assign sample_in.ready = (state_q == ST_LOAD);
  assign bin_out.valid   = (state_q == ST_OUT);
  assign bin_out.bin_re    = bin_re_q;
  assign bin_out.bin_im    = bin_im_q;
  assign bin_out.bin_index = bin_index_q;
  assign bin_out.bin_last  = bin_last_q;

  // butterfly addressing: logical index held at its bit-reversed address
  assign j6    = AW'(j_q);
  assign hmask = (6'd1 << stg_q) - 6'd1;
  assign la    = ((j6 >> stg_q) << (stg_q + 3'd1)) | (j6 & hmask);
  assign lb    = la | (6'd1 << stg_q);
  assign pa    = rev(la, lvl_q);
  assign pb    = rev(lb, lvl_q);
  assign ang   = (j6 & hmask) << (3'd5 - stg_q);
  assign jlast = 6'((7'd1 << lvl_q) >> 1) - 6'd1;
  assign mlast = 6'((7'd1 << lvl_q) - 7'd1);

  // first stage reads padded entries as zero
  always_comb begin
    zero_rd = 1'b0;
    if (stg_q == 3'd0) begin
      if (state_q == ST_RB) zero_rd = {1'b0, pa} >= n_q;
      if (state_q == ST_MUL) zero_rd = {1'b0, pb} >= n_q;
    end
  end
  assign rd_mux = zero_rd ? '0 : rdata_q;

  assign ctrl.cap_a = (state_q == ST_RB);
  assign ctrl.mul   = (state_q == ST_MUL);
  assign ctrl.add   = (state_q == ST_ADD);
  assign ctrl.inv   = inv_q;

  r2fft_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .rd_i   (rd_mux),
    .ang_i  (ang),
    .sum_o  (sum),
    .diff_o (diff)
  );

  assign s_re  = take(sample_in.sample_re);
  assign s_im  = take(sample_in.sample_im);
  assign n_new = (count_q < 7'(POINTS)) ? count_q + 7'd1 : count_q;

  // memory ports
  always_comb begin
    raddr = pa;
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = {s_re, s_im};
    case (state_q)
      ST_LOAD: begin
        we = in_acc && (count_q < 7'(POINTS));
      end
      ST_RB: begin
        raddr = pb;
      end
      ST_WA: begin
        we    = 1'b1;
        waddr = pa;
        wdata = sum;
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = pb;
        wdata = diff;
      end
      ST_ORD: begin
        raddr = rev(k_q, lvl_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    lvl_d   = lvl_q;
    stg_d   = stg_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          count_d = n_new;
          if (sample_in.frame_end) begin
            count_d = '0;
            n_d     = n_new;
            lvl_d   = clog2n(n_new);
            stg_d   = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = (clog2n(n_new) == 3'd0) ? ST_ORD : ST_RA;
          end
        end
      end
      ST_RA:  state_d = ST_RB;
      ST_RB:  state_d = ST_MUL;
      ST_MUL: state_d = ST_ADD;
      ST_ADD: state_d = ST_WA;
      ST_WA:  state_d = ST_WB;
      ST_WB: begin
        state_d = ST_RA;
        if (j6 == jlast) begin
          j_d   = '0;
          stg_d = stg_q + 3'd1;
          if (stg_q + 3'd1 == lvl_q) state_d = ST_ORD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_ORD:  state_d = ST_OCAP;
      ST_OCAP: state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          if (k_q == mlast) begin
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + 6'd1;
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      inv_q   <= 1'b0;
      count_q <= '0;
      n_q     <= '0;
      lvl_q   <= '0;
      stg_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      lvl_q   <= lvl_d;
      stg_q   <= stg_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (cfg_we_i) inv_q <= cfg_data_i;
    end
  end

  // output register, loaded once the bin read returns
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OCAP) begin
      bin_re_q    <= rdata_q[2*DW-1:DW];
      bin_im_q    <= rdata_q[DW-1:0];
      bin_index_q <= k_q;
      bin_last_q  <= (k_q == mlast);
    end
  end

endmodule

>>> hdl/r2fft_chk.sv
// port-level checker for the radix-2 fft engine, bound to the top level
// depends on radix2_fft_engine_defines.svh
`include "radix2_fft_engine_defines.svh"

module r2fft_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] bin_re_i,
  input logic [5:0]  bin_index_i,
  input logic        bin_last_i
);

  // no new sample while a bin is pending
  `R2F_ASSERT_NOW(a_no_overlap, out_valid_i, !in_ready_i, "sample taken during unload")

  // last bin closes a power-of-two frame
  `R2F_ASSERT_NOW(a_last_pow2, out_valid_i && bin_last_i,
    (bin_index_i & (bin_index_i + 6'd1)) == 6'd0, "last bin index not 2^k-1")

  // an accepted bin other than the last is followed by a gap with no valid bin
  `R2F_ASSERT_NEXT(a_bin_order, out_valid_i && out_ready_i && !bin_last_i,
    !out_valid_i, "bin shown again without gap")

  // stalled bin holds
  `R2F_ASSERT_NEXT(a_bin_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(bin_re_i) && $stable(bin_index_i), "stalled bin changed")

endmodule

bind radix2_fft_engine r2fft_chk u_r2fft_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_in.valid),
  .in_ready_i  (sample_in.ready),
  .out_valid_i (bin_out.valid),
  .out_ready_i (bin_out.ready),
  .bin_re_i    (bin_out.bin_re),
  .bin_index_i (bin_out.bin_index),
  .bin_last_i  (bin_out.bin_last)
);
